// ===== rtl/rob_pkg.sv =====
package rob_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIST_W    = 48;
	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int THR_W     = 16;
	localparam int FAR_W     = DIST_W - 1;
	localparam int DELTA_W   = COORD_W + 1;
	localparam int EP_W      = COORD_W + DELTA_W;
	localparam int FP_W      = COORD_W + DIR_W;
	localparam int E_W       = EP_W - FRAC_BITS + 2;
	localparam int F_W       = FP_W - FRAC_BITS + 2;
	localparam int NUM_W     = E_W + 1;
	localparam int QM_W      = DIST_W - 1;
	localparam int QSH       = QM_W - FRAC_BITS;
	localparam int SAT_W     = F_W + QSH;
	localparam int MCNT_W    = $clog2(COORD_W);
	localparam int DCNT_W    = $clog2(QM_W);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd7;

	localparam logic [1:0] AXIS_START = 2'd0;
	localparam logic [1:0] AXIS_END   = 2'd2;
	localparam logic [1:0] AXIS_SKIP  = 2'd3;

	localparam logic [DIR_W-1:0] DIR_Z_RESET  = DIR_W'(65536);
	localparam logic [THR_W-1:0] THR_RESET    = THR_W'(66);
	localparam logic [FAR_W-1:0] FAR_RESET    = FAR_W'(64'd6553600000);

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

endpackage

// ===== rtl/rob_mul.sv =====
module rob_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_x,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_y,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_z,
	input  logic signed [rob_pkg::DELTA_W-1:0] delta_x,
	input  logic signed [rob_pkg::DELTA_W-1:0] delta_y,
	input  logic signed [rob_pkg::DELTA_W-1:0] delta_z,
	input  logic signed [rob_pkg::DIR_W-1:0]   dir_x,
	input  logic signed [rob_pkg::DIR_W-1:0]   dir_y,
	input  logic signed [rob_pkg::DIR_W-1:0]   dir_z,
	output logic done,
	output logic signed [rob_pkg::E_W-1:0] e,
	output logic signed [rob_pkg::F_W-1:0] f
);
	import rob_pkg::*;

	logic busy_q, sum_q, done_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [COORD_W-1:0] ax_q, ay_q, az_q;
	logic signed [EP_W-1:0] mex_q, mey_q, mez_q, aex_q, aey_q, aez_q;
	logic signed [FP_W-1:0] mfx_q, mfy_q, mfz_q, afx_q, afy_q, afz_q;
	logic signed [E_W-1:0] e_q;
	logic signed [F_W-1:0] f_q;
	logic last;

	// serial multiply: multiplier bit of weight 2^(n-1) is negative
	function automatic logic signed [EP_W-1:0] step_e(input logic signed [EP_W-1:0] acc,
		input logic signed [EP_W-1:0] m, input logic b, input logic neg);
		logic signed [EP_W-1:0] add;
		add = b ? m : '0;
		return neg ? acc - add : acc + add;
	endfunction

	function automatic logic signed [FP_W-1:0] step_f(input logic signed [FP_W-1:0] acc,
		input logic signed [FP_W-1:0] m, input logic b, input logic neg);
		logic signed [FP_W-1:0] add;
		add = b ? m : '0;
		return neg ? acc - add : acc + add;
	endfunction

	function automatic logic signed [E_W-1:0] shr_e(input logic signed [EP_W-1:0] v);
		logic signed [EP_W-1:0] s;
		s = v >>> FRAC_BITS;
		return s[E_W-1:0];
	endfunction

	function automatic logic signed [F_W-1:0] shr_f(input logic signed [FP_W-1:0] v);
		logic signed [FP_W-1:0] s;
		s = v >>> FRAC_BITS;
		return s[F_W-1:0];
	endfunction

	assign last = (cnt_q == MCNT_W'(COORD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sum_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sum_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					sum_q  <= 1'b1;
				end
			end else if (sum_q) begin
				sum_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q  <= axis_x;
			ay_q  <= axis_y;
			az_q  <= axis_z;
			mex_q <= EP_W'(delta_x);
			mey_q <= EP_W'(delta_y);
			mez_q <= EP_W'(delta_z);
			mfx_q <= FP_W'(dir_x);
			mfy_q <= FP_W'(dir_y);
			mfz_q <= FP_W'(dir_z);
			aex_q <= '0;
			aey_q <= '0;
			aez_q <= '0;
			afx_q <= '0;
			afy_q <= '0;
			afz_q <= '0;
		end else if (busy_q) begin
			aex_q <= step_e(aex_q, mex_q, ax_q[0], last);
			aey_q <= step_e(aey_q, mey_q, ay_q[0], last);
			aez_q <= step_e(aez_q, mez_q, az_q[0], last);
			afx_q <= step_f(afx_q, mfx_q, ax_q[0], last);
			afy_q <= step_f(afy_q, mfy_q, ay_q[0], last);
			afz_q <= step_f(afz_q, mfz_q, az_q[0], last);
			mex_q <= mex_q <<< 1;
			mey_q <= mey_q <<< 1;
			mez_q <= mez_q <<< 1;
			mfx_q <= mfx_q <<< 1;
			mfy_q <= mfy_q <<< 1;
			mfz_q <= mfz_q <<< 1;
			ax_q  <= ax_q >> 1;
			ay_q  <= ay_q >> 1;
			az_q  <= az_q >> 1;
		end
		if (sum_q) begin
			e_q <= shr_e(aex_q) + shr_e(aey_q) + shr_e(aez_q);
			f_q <= shr_f(afx_q) + shr_f(afy_q) + shr_f(afz_q);
		end
	end

	assign done = done_q;
	assign e    = e_q;
	assign f    = f_q;

endmodule

// ===== rtl/rob_div.sv =====
module rob_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rob_pkg::NUM_W-1:0] n,
	input  logic [rob_pkg::F_W-1:0]   d,
	input  logic neg,
	output logic done,
	output logic signed [rob_pkg::DIST_W-1:0] t
);
	import rob_pkg::*;

	logic busy_q, fin_q, done_q, sat_q, neg_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [F_W-1:0] d_q, rem_q;
	logic [QM_W-1:0] sh_q;
	logic signed [DIST_W-1:0] t_q;
	logic sat;
	logic [F_W:0] r2, diff;
	logic ge;

	// quotient reaches 2^47 exactly when n >= d * 2^31
	assign sat  = {{(SAT_W-NUM_W){1'b0}}, n} >= {d, {QSH{1'b0}}};
	assign r2   = {rem_q, sh_q[QM_W-1]};
	assign ge   = r2 >= {1'b0, d_q};
	assign diff = r2 - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				fin_q  <= sat;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(QM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= sat;
			neg_q <= neg;
			d_q   <= d;
			rem_q <= F_W'(n[NUM_W-1:QSH]);
			sh_q  <= {n[QSH-1:0], {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? diff[F_W-1:0] : r2[F_W-1:0];
			sh_q  <= {sh_q[QM_W-2:0], ge};
		end
		if (fin_q) begin
			if (sat_q)
				t_q <= neg_q ? DIST_MIN : DIST_MAX;
			else
				t_q <= neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
		end
	end

	assign done = done_q;
	assign t    = t_q;

endmodule

// ===== rtl/ray_obb_slab_test_core.sv =====
// Flow: a word for a parallel axis passes the multiply, decide and finish states; when
// both plane distances are divided it also passes two divisions, and an already missed box
// goes straight to finish; a saturating quotient skips the divider's iterations.
// Throughput: one axis word in flight; a new word is taken only once the core is back in
// idle, which is held off further while the result stalls.
// Reset: async active low; registers take their reset values, box state cleared.
module ray_obb_slab_test_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] axis_index,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_x,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_y,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_z,
	input  logic signed [rob_pkg::COORD_W-1:0] center_x,
	input  logic signed [rob_pkg::COORD_W-1:0] center_y,
	input  logic signed [rob_pkg::COORD_W-1:0] center_z,
	input  logic signed [rob_pkg::COORD_W-1:0] slab_lo,
	input  logic signed [rob_pkg::COORD_W-1:0] slab_hi,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic [rob_pkg::FAR_W-1:0] entry_distance,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rob_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rob_pkg::FAR_W-1:0] cfg_data
);
	import rob_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic signed [COORD_W-1:0] org_x_q, org_y_q, org_z_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic [THR_W-1:0] thr_q;
	logic [FAR_W-1:0] far_lim_q;

	logic [1:0] idx_q;
	logic signed [COORD_W-1:0] lo_q, hi_q;
	logic signed [DIST_W-1:0] near_q, far_q, t1_q;
	logic missed_q;
	logic out_valid_q, hit_q;
	logic [FAR_W-1:0] entry_q;

	logic accept, eff_missed, mul_start, mul_done, div_start, div_done, div_neg;
	logic signed [DELTA_W-1:0] dx, dy, dz;
	logic signed [E_W-1:0] e;
	logic signed [F_W-1:0] f;
	logic [F_W-1:0] fa;
	logic signed [NUM_W-1:0] num1, num2, num_sel;
	logic [NUM_W-1:0] num_mag;
	logic signed [DIST_W-1:0] div_t, tmin, tmax, new_far, new_near;
	logic par, emit_ok, emit;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign eff_missed = (axis_index == AXIS_START) ? 1'b0 : missed_q;
	assign mul_start = accept && (axis_index != AXIS_SKIP) && !eff_missed;

	assign dx = DELTA_W'(center_x) - DELTA_W'(org_x_q);
	assign dy = DELTA_W'(center_y) - DELTA_W'(org_y_q);
	assign dz = DELTA_W'(center_z) - DELTA_W'(org_z_q);

	rob_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.delta_x(dx), .delta_y(dy), .delta_z(dz),
		.dir_x(dir_x_q), .dir_y(dir_y_q), .dir_z(dir_z_q),
		.done(mul_done), .e(e), .f(f)
	);

	assign fa      = f[F_W-1] ? F_W'(-f) : F_W'(f);
	assign num1    = NUM_W'(e) + NUM_W'(lo_q);
	assign num2    = NUM_W'(e) + NUM_W'(hi_q);
	assign par     = !(fa > F_W'(thr_q));
	assign num_sel = (state_q == ST_DEC) ? num1 : num2;
	assign num_mag = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
	assign div_neg = num_sel[NUM_W-1] ^ f[F_W-1];
	assign div_start = ((state_q == ST_DEC) && !par) || ((state_q == ST_DIV1) && div_done);

	rob_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(num_mag), .d(fa), .neg(div_neg),
		.done(div_done), .t(div_t)
	);

	assign tmin     = (t1_q > div_t) ? div_t : t1_q;
	assign tmax     = (t1_q > div_t) ? t1_q : div_t;
	assign new_far  = (tmax < far_q) ? tmax : far_q;
	assign new_near = (tmin > near_q) ? tmin : near_q;
	assign emit_ok  = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_FIN) && (idx_q == AXIS_END) && emit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q   <= '0;
			org_y_q   <= '0;
			org_z_q   <= '0;
			dir_x_q   <= '0;
			dir_y_q   <= '0;
			dir_z_q   <= DIR_Z_RESET;
			thr_q     <= THR_RESET;
			far_lim_q <= FAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_X: org_x_q   <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: org_y_q   <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z: org_z_q   <= cfg_data[COORD_W-1:0];
				REG_DIR_X:    dir_x_q   <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:    dir_y_q   <= cfg_data[DIR_W-1:0];
				REG_DIR_Z:    dir_z_q   <= cfg_data[DIR_W-1:0];
				REG_THRESH:   thr_q     <= cfg_data[THR_W-1:0];
				REG_FAR:      far_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			near_q      <= '0;
			far_q       <= DIST_W'(FAR_RESET);
			missed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (axis_index != AXIS_SKIP)) begin
						idx_q <= axis_index;
						if (axis_index == AXIS_START) begin
							near_q   <= '0;
							far_q    <= DIST_W'(far_lim_q);
							missed_q <= 1'b0;
						end
						state_q <= eff_missed ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (par) begin
						if ((num1 > 0) || (num2 < 0))
							missed_q <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done)
						state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						far_q    <= new_far;
						near_q   <= new_near;
						if (new_far < new_near)
							missed_q <= 1'b1;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (idx_q != AXIS_END) begin
						state_q <= ST_IDLE;
					end else if (emit_ok) begin
						near_q      <= '0;
						far_q       <= DIST_W'(far_lim_q);
						missed_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= slab_lo;
			hi_q <= slab_hi;
		end
		if ((state_q == ST_DIV1) && div_done)
			t1_q <= div_t;
		if (emit) begin
			hit_q   <= !missed_q;
			entry_q <= (missed_q || near_q[DIST_W-1]) ? '0 : near_q[FAR_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign entry_distance = entry_q;

endmodule

// ===== verif/ray_obb_slab_checker.sv =====
module ray_obb_slab_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [1:0] axis_index,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_x,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_y,
	input  logic signed [rob_pkg::COORD_W-1:0] axis_z,
	input  logic signed [rob_pkg::COORD_W-1:0] center_x,
	input  logic signed [rob_pkg::COORD_W-1:0] center_y,
	input  logic signed [rob_pkg::COORD_W-1:0] center_z,
	input  logic signed [rob_pkg::COORD_W-1:0] slab_lo,
	input  logic signed [rob_pkg::COORD_W-1:0] slab_hi,
	input  logic out_valid,
	input  logic out_stall,
	input  logic hit,
	input  logic [rob_pkg::FAR_W-1:0] entry_distance,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [rob_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rob_pkg::FAR_W-1:0] cfg_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rob_pkg::*;

	typedef struct packed {
		logic hit;
		logic [FAR_W-1:0] entry;
	} box_result_t;

	localparam longint CAP = longint'(1) << (DIST_W - 1);

	logic signed [COORD_W-1:0] org [3];
	logic signed [DIR_W-1:0] ray_dir [3];
	logic [THR_W-1:0] thr;
	logic [FAR_W-1:0] far_cfg;
	longint near_d, far_d;
	bit box_missed;
	box_result_t box_q [$];

	assign pending = box_q.size();

	function automatic longint slab_div(longint num, longint den);
		logic [127:0] n, d, q;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = 128'(num < 0 ? -num : num) << FRAC_BITS;
		d = 128'(den < 0 ? -den : den);
		q = n / d;
		if (q > 128'(CAP)) q = 128'(CAP);
		if (neg) return -longint'(q);
		if (q > 128'(CAP - 1)) q = 128'(CAP - 1);
		return longint'(q);
	endfunction

	function automatic void box_reload();
		near_d = 0;
		far_d = longint'(far_cfg);
		box_missed = 0;
	endfunction

	function automatic void fold_axis();
		logic signed [COORD_W-1:0] av [3];
		logic signed [COORD_W-1:0] cv [3];
		logic signed [65:0] a66, d66, prod;
		longint e, f, fa, t1, t2, w, lo, hi, nd;
		box_result_t r;
		if (axis_index == AXIS_SKIP) return;
		if (axis_index == AXIS_START) box_reload();
		av[0] = axis_x; av[1] = axis_y; av[2] = axis_z;
		cv[0] = center_x; cv[1] = center_y; cv[2] = center_z;
		lo = longint'(slab_lo);
		hi = longint'(slab_hi);
		if (!box_missed) begin
			e = 0;
			f = 0;
			for (int k = 0; k < 3; k++) begin
				a66 = av[k];
				d66 = longint'(cv[k]) - longint'(org[k]);
				prod = a66 * d66;
				e += longint'(prod >>> FRAC_BITS);
				f += (longint'(ray_dir[k]) * longint'(av[k])) >>> FRAC_BITS;
			end
			fa = f < 0 ? -f : f;
			if (fa > longint'(thr)) begin
				t1 = slab_div(e + lo, f);
				t2 = slab_div(e + hi, f);
				if (t1 > t2) begin
					w = t1; t1 = t2; t2 = w;
				end
				if (t2 < far_d) far_d = t2;
				if (t1 > near_d) near_d = t1;
				if (far_d < near_d) box_missed = 1;
			end else if (e + lo > 0 || e + hi < 0) begin
				box_missed = 1;
			end
		end
		if (axis_index != AXIS_END) return;
		if (box_missed) begin
			r = '0;
		end else begin
			nd = near_d < 0 ? 0 : near_d;
			r.hit = 1;
			r.entry = FAR_W'(nd);
		end
		box_q.push_back(r);
		box_reload();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		box_result_t x;
		if (!arst_n) begin
			org[0] = '0; org[1] = '0; org[2] = '0;
			ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = DIR_Z_RESET;
			thr = THR_RESET;
			far_cfg = FAR_RESET;
			box_reload();
			box_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_X: org[0] = cfg_data[COORD_W-1:0];
					REG_ORIGIN_Y: org[1] = cfg_data[COORD_W-1:0];
					REG_ORIGIN_Z: org[2] = cfg_data[COORD_W-1:0];
					REG_DIR_X:    ray_dir[0] = cfg_data[DIR_W-1:0];
					REG_DIR_Y:    ray_dir[1] = cfg_data[DIR_W-1:0];
					REG_DIR_Z:    ray_dir[2] = cfg_data[DIR_W-1:0];
					REG_THRESH:   thr = cfg_data[THR_W-1:0];
					REG_FAR:      far_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) fold_axis();
			if (out_valid && !out_stall) begin
				if (box_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: hit=%0d dist=%0d", hit, entry_distance);
				end else begin
					x = box_q.pop_front();
					if (hit !== x.hit || entry_distance !== x.entry) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
								x.hit, x.entry, hit, entry_distance);
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_ray_obb_slab_test_core.sv =====
module tb_ray_obb_slab_test_core;
	timeunit 1ns;
	timeprecision 1ps;
	import rob_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] axis_index = '0;
	logic signed [COORD_W-1:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic signed [COORD_W-1:0] center_x = '0, center_y = '0, center_z = '0;
	logic signed [COORD_W-1:0] slab_lo = '0, slab_hi = '0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic [FAR_W-1:0] entry_distance;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FAR_W-1:0] cfg_data = '0;
	int errors, pending;
	int cycles = 0;
	int burst_left = 4;
	int stall_mode = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	ray_obb_slab_test_core i_dut (.*);

	ray_obb_slab_checker i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= $urandom_range(0, 1);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= ((cycles / 7) % 3 == 0);
		endcase
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FAR_W-1:0] val);
		bit rdy;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do begin
			@(negedge clk) rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_axis(input logic [1:0] ix,
			input logic signed [31:0] ax, ay, az, cx, cy, cz, lo, hi);
		bit st;
		int g;
		axis_index <= ix;
		axis_x <= ax; axis_y <= ay; axis_z <= az;
		center_x <= cx; center_y <= cy; center_z <= cz;
		slab_lo <= lo; slab_hi <= hi;
		in_valid <= 1;
		do begin
			@(negedge clk) st = in_stall;
			@(posedge clk);
		end while (st);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			g = $urandom_range(1, 40);
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rnd_small(int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	task automatic random_box();
		logic signed [31:0] a [3];
		logic signed [31:0] cx, cy, cz, lo, hi;
		int mode, perm;
		mode = $urandom_range(0, 9);
		cx = rnd_small(200 << 16);
		cy = rnd_small(200 << 16);
		cz = rnd_small(200 << 16);
		perm = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			if (mode < 7) begin
				a[0] = 0; a[1] = 0; a[2] = 0;
				a[(k + perm) % 3] = $urandom_range(0, 1) ? 65536 : -65536;
				if ($urandom_range(0, 2) == 0) begin
					a[0] += rnd_small(20000);
					a[1] += rnd_small(20000);
					a[2] += rnd_small(20000);
				end
				lo = -int'($urandom_range(0, 60 << 16));
				hi = $urandom_range(0, 60 << 16);
				if ($urandom_range(0, 9) == 0) begin
					lo = hi + 1;
				end
			end else begin
				a[0] = $urandom; a[1] = $urandom; a[2] = $urandom;
				cx = $urandom; cy = $urandom; cz = $urandom;
				lo = $urandom; hi = $urandom;
			end
			send_axis((mode == 9) ? 2'($urandom_range(0, 3)) : 2'(k),
				a[0], a[1], a[2], cx, cy, cz, lo, hi);
		end
	endtask

	task automatic set_phase(input int p);
		int d;
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		case (p)
			1: begin
				write_reg(REG_ORIGIN_X, FAR_W'(32'h7fffffff));
				write_reg(REG_ORIGIN_Y, FAR_W'(32'h7fffffff));
				write_reg(REG_ORIGIN_Z, FAR_W'(32'h7fffffff));
				write_reg(REG_DIR_X, FAR_W'(18'(-65536)));
				write_reg(REG_DIR_Y, '0);
				write_reg(REG_DIR_Z, '0);
				write_reg(REG_THRESH, '0);
				write_reg(REG_FAR, {FAR_W{1'b1}});
			end
			2: begin
				write_reg(REG_ORIGIN_X, FAR_W'(32'h80000000));
				write_reg(REG_ORIGIN_Y, FAR_W'(32'h80000000));
				write_reg(REG_ORIGIN_Z, FAR_W'(32'h80000000));
				write_reg(REG_DIR_X, '0);
				write_reg(REG_DIR_Y, FAR_W'(18'd65536));
				write_reg(REG_THRESH, FAR_W'(16'hffff));
				write_reg(REG_FAR, FAR_W'(1));
			end
			default: begin
				write_reg(REG_ORIGIN_X, FAR_W'(rnd_small(100 << 16)));
				write_reg(REG_ORIGIN_Y, FAR_W'(rnd_small(100 << 16)));
				write_reg(REG_ORIGIN_Z, FAR_W'(rnd_small(100 << 16)));
				d = $urandom_range(0, 2);
				for (int k = 0; k < 3; k++)
					write_reg(CFG_IDX_W'(int'(REG_DIR_X) + k), FAR_W'(18'((k == d) ?
						($urandom_range(0, 1) ? 65536 : -65536) : rnd_small(30000))));
				write_reg(REG_THRESH, FAR_W'($urandom_range(0, 400)));
				write_reg(REG_FAR, FAR_W'($urandom_range(1000, 30000)) << 16);
			end
		endcase
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// hit along z from the origin
		send_axis(AXIS_START, 65536, 0, 0, 0, 0, 10 << 16, -(1 << 16), 1 << 16);
		send_axis(2'd1, 0, 65536, 0, 0, 0, 10 << 16, -(1 << 16), 1 << 16);
		send_axis(AXIS_END, 0, 0, 65536, 0, 0, 10 << 16, -(1 << 16), 1 << 16);
		// parallel slab miss, then sticky
		send_axis(AXIS_START, 65536, 0, 0, 5 << 16, 0, 10 << 16, -(1 << 16), 1 << 16);
		send_axis(2'd1, 0, 0, 65536, 0, 0, 10 << 16, -(1 << 16), 1 << 16);
		send_axis(AXIS_END, 0, 0, -65536, 0, 0, 3 << 16, -(9 << 16), 9 << 16);
		// box behind the origin
		send_axis(AXIS_START, 0, 0, 65536, 0, 0, -(10 << 16), -(1 << 16), 1 << 16);
		send_axis(AXIS_END, 65536, 0, 0, 0, 0, -(10 << 16), -(1 << 16), 1 << 16);
		// missing start, skipped index
		send_axis(2'd1, 0, 0, 65536, 0, 0, 4 << 16, -(2 << 16), 2 << 16);
		send_axis(AXIS_SKIP, -1, -1, -1, -1, -1, -1, -1, -1);
		send_axis(AXIS_END, 0, 0, 65536, 0, 0, 4 << 16, -(1 << 16), 1 << 16);
		// field extremes
		send_axis(AXIS_START, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_axis(2'd1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_axis(AXIS_END, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		// huge quotient: tiny f, wide slab
		send_axis(AXIS_START, 0, 0, 67, 0, 0, 32'h7fff0000, 32'h80000000, 32'h7fffffff);
		send_axis(AXIS_END, 0, 0, -67, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);

		for (int p = 0; p < 8; p++) begin
			if (p > 0) set_phase(p);
			if (p == 1) begin
				send_axis(AXIS_START, 32'h80000000, 0, 0, 32'h80000000, 0, 0,
					32'h80000000, 32'h7fffffff);
				send_axis(AXIS_END, 1 << 16, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff);
			end
			for (int b = 0; b < 35; b++) random_box();
		end

		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
